[rtl/mwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwc_pkg
// Shared types, command codes and constants for the microwave cooking
// controller core.
// ----------------------------------------------------------------------------
package mwc_pkg;

   // Command codes carried by an input transaction.
   localparam logic [2:0] CMD_DIGIT  = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_CANCEL = 3'd2;
   localparam logic [2:0] CMD_DOOR   = 3'd3;
   localparam logic [2:0] CMD_FOOD   = 3'd4;
   localparam logic [2:0] CMD_TICK   = 3'd5;

   localparam int DIGIT_COUNT  = 4;
   localparam int DIGIT_BASE   = 10;
   localparam int SECS_PER_MIN = 60;

   // Largest count that fits the MM:SS display (99:59), and the clamp values.
   localparam logic [12:0] DISPLAY_MAX  = 13'd5999;
   localparam logic [6:0]  CLAMP_MINS   = 7'd99;
   localparam logic [6:0]  CLAMP_SECS   = 7'd59;
   localparam logic [3:0]  MAX_KEY      = 4'd9;

   // Reciprocal of sixty scaled by two to the twentieth, rounded up. Exact
   // quotient for every count up to the display limit.
   localparam int          RECIP_SHIFT  = 20;
   localparam logic [14:0] RECIP_60     = 15'd17477;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] key_digit;
   } req_type;

   typedef struct packed {
      logic        heating;
      logic        door_closed;
      logic        food_present;
      logic        time_entered;
      logic [3:0]  minute_tens;
      logic [3:0]  minute_ones;
      logic [3:0]  second_tens;
      logic [3:0]  second_ones;
      logic [12:0] remaining_seconds;
   } rsp_type;

   typedef struct packed {
      logic [3:0] minute_tens;
      logic [3:0] minute_ones;
      logic [3:0] second_tens;
      logic [3:0] second_ones;
   } digits_type;

   // Tens digit of a value below one hundred, by parallel threshold compares.
   function automatic logic [3:0] tens_of(input logic [6:0] value);
      logic [8:0] above;
      for (int k = 1; k <= 9; k++) begin
         above[k-1] = (value >= 7'(k * DIGIT_BASE));
      end
      return 4'($countones(above));
   endfunction

   // Ones digit of a value below one hundred, given its tens digit.
   function automatic logic [3:0] ones_of(input logic [6:0] value, input logic [3:0] tens);
      logic [6:0] tens_x10;
      tens_x10 = (7'(tens) << 3) + (7'(tens) << 1);
      return 4'(value - tens_x10);
   endfunction

endpackage

[rtl/microwave_cooking_controller_core.sv]
// An accepted input transaction waits in the input register, then its status
// transaction in the result register. Throughput: one transaction per cycle
// unless the result channel stalls, set by the single state update path.
// Reset: synchronous and active high; clears the digits, the time-set flag,
// the remaining count, heating, the door flag (open) and the food flag.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwave_cooking_controller_core
// Microwave oven controller: keypad entry, start and cancel, door and food
// sensing and a one-second countdown, one status transaction per event.
// ----------------------------------------------------------------------------
module microwave_cooking_controller_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mwc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mwc_pkg::rsp_type  rsp_data
);
   import mwc_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type next_status;
   logic    out_free;
   logic    step;

   // Handshake control: the input stage advances whenever the result
   // register is empty or being drained.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign step         = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || out_free;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Event handling and oven state.
   mwc_state u_state (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .req         (in_data_ff),
      .next_status (next_status)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= next_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // Heating always has seconds left to count.
   a_heat_has_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.heating) |-> (rsp_data_ff.remaining_seconds != '0))
      else $error("heating reported with no seconds remaining");

   // The remaining count is zero whenever the oven is idle.
   a_idle_no_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.heating) |-> (rsp_data_ff.remaining_seconds == '0))
      else $error("seconds remaining while idle");

   // Heating implies the time is set.
   a_heat_time_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.heating) |-> rsp_data_ff.time_entered)
      else $error("heating without the time set");

   // A held input transaction keeps its payload until it moves on.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input register lost a stalled transaction");

   // Every applied transaction produces a result.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("applied transaction produced no result");
`endif

endmodule

[rtl/mwc_time_split.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwc_time_split
// Converts a count of seconds into the four MM:SS display digits, clamping
// to 99:59 when the count is too large for the display.
// ----------------------------------------------------------------------------
module mwc_time_split (
   input  logic [12:0]            seconds,
   output mwc_pkg::digits_type    digits
);
   import mwc_pkg::*;

   logic [27:0] product;
   logic [6:0]  mins;
   logic [12:0] mins_x60;
   logic [6:0]  secs;
   logic [6:0]  mins_sel;
   logic [6:0]  secs_sel;
   logic [3:0]  mins_tens;
   logic [3:0]  secs_tens;

   // Minutes by reciprocal multiplication, seconds as the remainder.
   assign product  = 28'(seconds) * 28'(RECIP_60);
   assign mins     = 7'(product >> RECIP_SHIFT);
   assign mins_x60 = (13'(mins) << 6) - (13'(mins) << 2);
   assign secs     = 7'(seconds - mins_x60);

   // Counts beyond the display show the largest displayable time.
   assign mins_sel = (seconds > DISPLAY_MAX) ? CLAMP_MINS : mins;
   assign secs_sel = (seconds > DISPLAY_MAX) ? CLAMP_SECS : secs;

   // Split both halves into decimal digits.
   assign mins_tens = tens_of(mins_sel);
   assign secs_tens = tens_of(secs_sel);

   assign digits.minute_tens = mins_tens;
   assign digits.minute_ones = ones_of(mins_sel, mins_tens);
   assign digits.second_tens = secs_tens;
   assign digits.second_ones = ones_of(secs_sel, secs_tens);

endmodule

[rtl/mwc_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwc_state
// Oven state registers and event handling. Applies one transaction per
// enabled cycle and presents the resulting status for the output register.
// ----------------------------------------------------------------------------
module mwc_state (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  mwc_pkg::req_type  req,
   output mwc_pkg::rsp_type  next_status
);
   import mwc_pkg::*;

   localparam logic [1:0] LAST_POS = 2'(DIGIT_COUNT - 1);

   logic [3:0]  digit_ff [DIGIT_COUNT];
   logic [3:0]  digit_in [DIGIT_COUNT];
   logic [1:0]  entry_ff;
   logic [1:0]  entry_in;
   logic        time_set_ff;
   logic        time_set_in;
   logic [12:0] seconds_ff;
   logic [12:0] seconds_in;
   logic        heating_ff;
   logic        heating_in;
   logic        door_ff;
   logic        door_in;
   logic        food_ff;
   logic        food_in;

   logic [6:0]  entry_mins;
   logic [6:0]  entry_secs;
   logic [12:0] total;
   logic [12:0] seconds_dec;
   digits_type  shown;

   // Total cooking time from the entered digits.
   assign entry_mins = (7'(digit_ff[0]) << 3) + (7'(digit_ff[0]) << 1) + 7'(digit_ff[1]);
   assign entry_secs = (7'(digit_ff[2]) << 3) + (7'(digit_ff[2]) << 1) + 7'(digit_ff[3]);
   assign total      = (13'(entry_mins) << 6) - (13'(entry_mins) << 2) + 13'(entry_secs);

   // Display digits for the count after one tick.
   assign seconds_dec = seconds_ff - 13'd1;

   mwc_time_split u_time_split (
      .seconds (seconds_dec),
      .digits  (shown)
   );

   // Next state for the transaction being applied.
   always_comb begin
      digit_in    = digit_ff;
      entry_in    = entry_ff;
      time_set_in = time_set_ff;
      seconds_in  = seconds_ff;
      heating_in  = heating_ff;
      door_in     = door_ff;
      food_in     = food_ff;

      if (step) begin
         unique case (req.command)
            CMD_DIGIT: begin
               if (!heating_ff && !time_set_ff && (req.key_digit <= MAX_KEY)) begin
                  digit_in[entry_ff] = req.key_digit;
                  if (entry_ff == LAST_POS) begin
                     entry_in    = '0;
                     time_set_in = 1'b1;
                  end else begin
                     entry_in = entry_ff + 2'd1;
                  end
               end
            end
            CMD_START: begin
               if (!heating_ff && time_set_ff && food_ff && door_ff) begin
                  if (total != '0) begin
                     seconds_in = total;
                     heating_in = 1'b1;
                  end else begin
                     digit_in    = '{default: '0};
                     entry_in    = '0;
                     time_set_in = 1'b0;
                     seconds_in  = '0;
                  end
               end
            end
            CMD_CANCEL: begin
               heating_in  = 1'b0;
               digit_in    = '{default: '0};
               entry_in    = '0;
               time_set_in = 1'b0;
               seconds_in  = '0;
            end
            CMD_DOOR: begin
               door_in = !door_ff;
            end
            CMD_FOOD: begin
               food_in = !food_ff;
            end
            CMD_TICK: begin
               if (heating_ff) begin
                  // The last second, or an already empty count, ends cooking.
                  if (seconds_ff <= 13'd1) begin
                     heating_in  = 1'b0;
                     digit_in    = '{default: '0};
                     entry_in    = '0;
                     time_set_in = 1'b0;
                     seconds_in  = '0;
                  end else begin
                     seconds_in  = seconds_dec;
                     digit_in[0] = shown.minute_tens;
                     digit_in[1] = shown.minute_ones;
                     digit_in[2] = shown.second_tens;
                     digit_in[3] = shown.second_ones;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff    <= '{default: '0};
         entry_ff    <= '0;
         time_set_ff <= 1'b0;
         seconds_ff  <= '0;
         heating_ff  <= 1'b0;
         door_ff     <= 1'b0;
         food_ff     <= 1'b0;
      end else begin
         digit_ff    <= digit_in;
         entry_ff    <= entry_in;
         time_set_ff <= time_set_in;
         seconds_ff  <= seconds_in;
         heating_ff  <= heating_in;
         door_ff     <= door_in;
         food_ff     <= food_in;
      end
   end

   // Status after the transaction, captured by the output register.
   assign next_status.heating           = heating_in;
   assign next_status.door_closed       = door_in;
   assign next_status.food_present      = food_in;
   assign next_status.time_entered      = time_set_in;
   assign next_status.minute_tens       = digit_in[0];
   assign next_status.minute_ones       = digit_in[1];
   assign next_status.second_tens       = digit_in[2];
   assign next_status.second_ones       = digit_in[3];
   assign next_status.remaining_seconds = seconds_in;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the microwave cooking controller core. A short
// scripted run exercises invalid keys, unused commands, display clamping and
// cancel and start in several states. A long run of randomised cooking
// sessions follows, with noise events mixed in. Each status is checked field
// by field against an in-bench oven model or a fixed scripted value. Both
// channels idle at random, with one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_top;
   import mwc_pkg::*;

   // Command codes that the core reports on but otherwise ignores.
   localparam logic [2:0] CMD_UNUSED_A = 3'd6;
   localparam logic [2:0] CMD_UNUSED_B = 3'd7;

   localparam int RANDOM_EVENTS = 1350;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_AT       = 600;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_AT      = 900;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      req_type ev;
      bit      typed;
      rsp_type want;
   } oven_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Model of the oven, advanced once per accepted input transaction.
   logic [3:0]  oven_digits [DIGIT_COUNT];
   logic [1:0]  oven_entry    = '0;
   logic        oven_time_set = 1'b0;
   logic        oven_heating  = 1'b0;
   logic        oven_door     = 1'b0;
   logic        oven_food     = 1'b0;
   logic [12:0] oven_left     = '0;

   oven_row_type oven_script [$];
   rsp_type      status_queue [$];

   // Door and food state as the script will leave them, used to plan sessions.
   logic plan_door = 1'b0;
   logic plan_food = 1'b0;

   int burst_left   = 0;
   int fault_count  = 0;
   int results_seen = 0;
   int stall_cycles = 0;

   microwave_cooking_controller_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Zero the digits, the entry position, the time-set flag and the count.
   function automatic void clear_oven_settings();
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         oven_digits[k] = '0;
      end
      oven_entry    = '0;
      oven_time_set = 1'b0;
      oven_left     = '0;
   endfunction

   // Apply one event to the model and return the status it should report.
   function automatic rsp_type advance_oven(input req_type ev);
      int unsigned total;
      int unsigned mins;
      int unsigned secs;
      rsp_type     status;
      case (ev.command)
         CMD_DIGIT: begin
            if (!oven_heating && !oven_time_set && ev.key_digit <= MAX_KEY) begin
               oven_digits[oven_entry] = ev.key_digit;
               if (oven_entry == 2'(DIGIT_COUNT - 1)) begin
                  oven_time_set = 1'b1;
               end
               oven_entry = oven_entry + 2'd1;
            end
         end
         CMD_START: begin
            if (!oven_heating && oven_time_set && oven_food && oven_door) begin
               total = (oven_digits[0] * DIGIT_BASE + oven_digits[1]) * SECS_PER_MIN
                     + oven_digits[2] * DIGIT_BASE + oven_digits[3];
               if (total > 0) begin
                  oven_left    = total[12:0];
                  oven_heating = 1'b1;
               end else begin
                  clear_oven_settings();
               end
            end
         end
         CMD_CANCEL: begin
            oven_heating = 1'b0;
            clear_oven_settings();
         end
         CMD_DOOR: oven_door = !oven_door;
         CMD_FOOD: oven_food = !oven_food;
         CMD_TICK: begin
            if (oven_heating) begin
               if (oven_left != 0) begin
                  oven_left = oven_left - 13'd1;
                  // Counts beyond 99:59 show the clamp value on the display.
                  if (oven_left > DISPLAY_MAX) begin
                     mins = CLAMP_MINS;
                     secs = CLAMP_SECS;
                  end else begin
                     mins = oven_left / SECS_PER_MIN;
                     secs = oven_left % SECS_PER_MIN;
                  end
                  oven_digits[0] = 4'(mins / DIGIT_BASE);
                  oven_digits[1] = 4'(mins % DIGIT_BASE);
                  oven_digits[2] = 4'(secs / DIGIT_BASE);
                  oven_digits[3] = 4'(secs % DIGIT_BASE);
               end
               if (oven_left == 0) begin
                  oven_heating = 1'b0;
                  clear_oven_settings();
               end
            end
         end
         default: ;
      endcase
      status.heating           = oven_heating;
      status.door_closed       = oven_door;
      status.food_present      = oven_food;
      status.time_entered      = oven_time_set;
      status.minute_tens       = oven_digits[0];
      status.minute_ones       = oven_digits[1];
      status.second_tens       = oven_digits[2];
      status.second_ones       = oven_digits[3];
      status.remaining_seconds = oven_left;
      return status;
   endfunction

   // Append one event to the script; a typed row carries an idle status with
   // the given door and food flags as its expected value.
   function automatic void add_row(input logic [2:0] cmd, input logic [3:0] key,
                                   input bit typed, input logic door, input logic food);
      oven_row_type row;
      row.ev    = req_type'({cmd, key});
      row.typed = typed;
      row.want  = '0;
      row.want.door_closed  = door;
      row.want.food_present = food;
      oven_script.push_back(row);
      if (cmd == CMD_DOOR) plan_door = !plan_door;
      if (cmd == CMD_FOOD) plan_food = !plan_food;
   endfunction

   // One random cooking session: mostly well formed, sometimes broken or noise.
   task automatic plan_cook_session();
      logic [3:0]  pick [DIGIT_COUNT];
      int unsigned style;
      int unsigned total;
      int unsigned ticks;
      style = $urandom_range(0, 15);
      if (style == 0) begin
         repeat ($urandom_range(1, 6)) begin
            add_row(3'($urandom_range(0, 7)), 4'($urandom()), 0, 0, 0);
         end
         return;
      end
      // A cancel first restarts digit entry and stops any cooking.
      if (style != 1) add_row(CMD_CANCEL, 4'($urandom()), 0, 0, 0);
      if ($urandom_range(0, 3) == 0) begin
         for (int k = 0; k < DIGIT_COUNT; k++) pick[k] = 4'($urandom_range(0, 9));
      end else begin
         pick[0] = '0;
         pick[1] = ($urandom_range(0, 3) == 0) ? 4'd1 : 4'd0;
         pick[2] = 4'($urandom_range(0, 2));
         pick[3] = 4'($urandom_range(0, 9));
      end
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if ($urandom_range(0, 9) == 0) add_row(CMD_DIGIT, 4'($urandom_range(10, 15)), 0, 0, 0);
         if (style == 2 && k == 2) begin
            add_row(CMD_CANCEL, 4'($urandom()), 0, 0, 0);
            return;
         end
         add_row(CMD_DIGIT, pick[k], 0, 0, 0);
      end
      // Close the door and load food unless this session is meant to fail.
      if (!plan_door && style != 3) add_row(CMD_DOOR, 4'($urandom()), 0, 0, 0);
      if (!plan_food && style != 4) add_row(CMD_FOOD, 4'($urandom()), 0, 0, 0);
      add_row(CMD_START, 4'($urandom()), 0, 0, 0);
      total = (pick[0] * DIGIT_BASE + pick[1]) * SECS_PER_MIN + pick[2] * DIGIT_BASE + pick[3];
      ticks = (total <= 45) ? total + $urandom_range(0, 2) : $urandom_range(1, 40);
      repeat (ticks) begin
         if ($urandom_range(0, 11) == 0) add_row(3'($urandom_range(0, 4)), 4'($urandom()), 0, 0, 0);
         add_row(CMD_TICK, 4'($urandom()), 0, 0, 0);
      end
   endtask

   // Offer one input transaction, idling between bursts, and record the
   // status it should produce once it is accepted.
   task automatic drive_event(input oven_row_type row);
      rsp_type status;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= row.ev;
      do @(posedge clock); while (!req_ready);
      status = advance_oven(row.ev);
      status_queue.push_back(row.typed ? row.want : status);
   endtask

   function automatic string show_status(input rsp_type s);
      return $sformatf("heat=%0b door=%0b food=%0b set=%0b %0d%0d:%0d%0d left=%0d",
                       s.heating, s.door_closed, s.food_present, s.time_entered,
                       s.minute_tens, s.minute_ones, s.second_tens, s.second_ones,
                       s.remaining_seconds);
   endfunction

   // Stimulus: scripted events first, then random sessions.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      for (int k = 0; k < DIGIT_COUNT; k++) oven_digits[k] = '0;

      add_row(CMD_UNUSED_A, 4'd0,  1, 0, 0);
      add_row(CMD_UNUSED_B, 4'd15, 1, 0, 0);
      add_row(CMD_DIGIT,    4'd15, 1, 0, 0);
      add_row(CMD_TICK,     4'd0,  1, 0, 0);
      add_row(CMD_START,    4'd0,  1, 0, 0);
      add_row(CMD_DOOR,     4'd0,  1, 1, 0);
      add_row(CMD_FOOD,     4'd0,  1, 1, 1);
      add_row(CMD_CANCEL,   4'd0,  1, 1, 1);
      // 99:99 overflows the display once the countdown begins.
      repeat (DIGIT_COUNT) add_row(CMD_DIGIT, 4'd9, 0, 0, 0);
      add_row(CMD_DIGIT,  4'd3, 0, 0, 0);
      add_row(CMD_START,  4'd0, 0, 0, 0);
      add_row(CMD_TICK,   4'd0, 0, 0, 0);
      add_row(CMD_DIGIT,  4'd5, 0, 0, 0);
      add_row(CMD_FOOD,   4'd0, 0, 0, 0);
      add_row(CMD_START,  4'd0, 0, 0, 0);
      add_row(CMD_CANCEL, 4'd0, 0, 0, 0);
      add_row(CMD_FOOD,   4'd0, 0, 0, 0);
      // A zero total clears the settings instead of heating.
      repeat (DIGIT_COUNT) add_row(CMD_DIGIT, 4'd0, 0, 0, 0);
      add_row(CMD_START,  4'd0, 0, 0, 0);

      while (oven_script.size() < RANDOM_EVENTS + 25) plan_cook_session();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (oven_script[n]) begin
         // Hold the input back once until every outstanding status is in.
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            while (status_queue.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         drive_event(oven_script[n]);
      end
      req_valid <= 1'b0;

      while (status_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Receiver: checks each status transaction and stalls on its own pattern.
   initial begin
      int ready_clock;
      int hold_left;
      bit hold_done;
      rsp_type want;
      ready_clock = 0;
      hold_left   = 0;
      hold_done   = 1'b0;
      rsp_ready  <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (status_queue.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("status %0d arrived with nothing expected: %s",
                           results_seen, show_status(rsp_data));
            end else begin
               want = status_queue.pop_front();
               if (rsp_data.heating !== want.heating
                   || rsp_data.door_closed !== want.door_closed
                   || rsp_data.food_present !== want.food_present
                   || rsp_data.time_entered !== want.time_entered
                   || rsp_data.minute_tens !== want.minute_tens
                   || rsp_data.minute_ones !== want.minute_ones
                   || rsp_data.second_tens !== want.second_tens
                   || rsp_data.second_ones !== want.second_ones
                   || rsp_data.remaining_seconds !== want.remaining_seconds) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("status %0d mismatch: expected %s, got %s",
                              results_seen, show_status(want), show_status(rsp_data));
               end
            end
         end
         // One long hold-off lets the core fill up and stall its input.
         ready_clock++;
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            case ((ready_clock / 128) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (ready_clock % 3 != 0);
            endcase
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

[microwave_cooking_controller_core.f]
rtl/mwc_pkg.sv
rtl/mwc_time_split.sv
rtl/mwc_state.sv
rtl/microwave_cooking_controller_core.sv
bench/tb_top.sv
